### design/vedc_pkg.sv
// Package for the variable-coefficient error diffusion weight block.
// Holds the halved weight table, pipeline types and the divider step functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vedc_pkg;

   localparam int CHANNELS      = 4;
   localparam int TABLE_ENTRIES = 256;
   localparam int HALF_ENTRIES  = TABLE_ENTRIES / 2;
   localparam int POS_STAGES    = 8;   // 16 quotient bits, 2 per stage
   localparam int BLEND_STAGES  = 8;   // 16 of 17 quotient bits, last one in the output stage
   localparam logic [15:0] POS_MAX    = 16'd65280;
   localparam logic [15:0] WEIGHT_MAX = 16'hFFFF;
   localparam logic [15:0] CSR_RESET  = 16'd255;

   // neighbor sequence, one-hot
   typedef enum logic [2:0] {
      NB_RIGHT    = 3'b001,
      NB_DOWNLEFT = 3'b010,
      NB_DOWN     = 3'b100
   } nb_type;

   typedef struct packed {
      logic [9:0] r;
      logic [9:0] dl;
      logic [9:0] d;
      logic [9:0] s;
   } coef_type;

   // first half of the table, the second half mirrors it
   localparam coef_type HALF_TABLE [HALF_ENTRIES] = '{
      '{13,0,5,18},'{13,0,5,18},'{21,0,10,31},'{7,0,4,11},
      '{8,0,5,13},'{47,3,28,78},'{23,3,13,39},'{15,3,8,26},
      '{22,6,11,39},'{43,15,20,78},'{7,3,3,13},'{501,224,211,936},
      '{249,116,103,468},'{165,80,67,312},'{123,62,49,234},'{489,256,191,936},
      '{81,44,31,156},'{483,272,181,936},'{60,35,22,117},'{53,32,19,104},
      '{237,148,83,468},'{471,304,161,936},'{3,2,1,6},'{459,304,161,924},
      '{38,25,14,77},'{453,296,175,924},'{225,146,91,462},'{149,96,63,308},
      '{111,71,49,231},'{63,40,29,132},'{73,46,35,154},'{435,272,217,924},
      '{108,67,56,231},'{13,8,7,28},'{213,130,119,462},'{423,256,245,924},
      '{5,3,3,11},'{281,173,162,616},'{141,89,78,308},'{283,183,150,616},
      '{71,47,36,154},'{285,193,138,616},'{13,9,6,28},'{41,29,18,88},
      '{36,26,15,77},'{289,213,114,616},'{145,109,54,308},'{291,223,102,616},
      '{73,57,24,154},'{293,233,90,616},'{21,17,6,44},'{295,243,78,616},
      '{37,31,9,77},'{27,23,6,56},'{149,129,30,308},'{299,263,54,616},
      '{75,67,12,154},'{43,39,6,88},'{151,139,18,308},'{303,283,30,616},
      '{38,36,3,77},'{305,293,18,616},'{153,149,6,308},'{307,303,6,616},
      '{1,1,0,2},'{101,105,2,208},'{49,53,2,104},'{95,107,6,208},
      '{23,27,2,52},'{89,109,10,208},'{43,55,6,104},'{83,111,14,208},
      '{5,7,1,13},'{172,181,37,390},'{97,76,22,195},'{72,41,17,130},
      '{119,47,29,195},'{4,1,1,6},'{4,1,1,6},'{4,1,1,6},
      '{4,1,1,6},'{4,1,1,6},'{4,1,1,6},'{4,1,1,6},
      '{4,1,1,6},'{4,1,1,6},'{65,18,17,100},'{95,29,26,150},
      '{185,62,53,300},'{30,11,9,50},'{35,14,11,60},'{85,37,28,150},
      '{55,26,19,100},'{80,41,29,150},'{155,86,59,300},'{5,3,2,10},
      '{5,3,2,10},'{5,3,2,10},'{5,3,2,10},'{5,3,2,10},
      '{5,3,2,10},'{5,3,2,10},'{5,3,2,10},'{5,3,2,10},
      '{5,3,2,10},'{5,3,2,10},'{5,3,2,10},'{5,3,2,10},
      '{305,176,119,600},'{155,86,59,300},'{105,56,39,200},'{80,41,29,150},
      '{65,32,23,120},'{55,26,19,100},'{335,152,113,600},'{85,37,28,150},
      '{115,48,37,200},'{35,14,11,60},'{355,136,109,600},'{30,11,9,50},
      '{365,128,107,600},'{185,62,53,300},'{25,8,7,40},'{95,29,26,150},
      '{385,112,103,600},'{65,18,17,100},'{395,104,101,600},'{4,1,1,6}
   };

   function automatic coef_type table_entry(input logic [7:0] idx);
      logic [6:0] h;
      h = idx[7] ? ~idx[6:0] : idx[6:0];
      return HALF_TABLE[h];
   endfunction

   // position divider state: (65280*sample) / max
   typedef struct packed {
      logic [1:0]  chan;
      nb_type      nb;
      logic        sat;
      logic [15:0] mx;
      logic [15:0] rem;
      logic [15:0] dvd;
      logic [15:0] quo;
   } pdiv_type;

   // blend divider state: (num << 8) / (s_lo*s_hi)
   typedef struct packed {
      logic [1:0]  chan;
      nb_type      nb;
      logic [19:0] den;
      logic [19:0] rem;
      logic [16:0] dvd;
      logic [16:0] quo;
   } bdiv_type;

   function automatic pdiv_type pos_step(input pdiv_type st);
      logic [16:0] r2;
      pdiv_type    o;
      o     = st;
      r2    = {st.rem, st.dvd[15]};
      o.dvd = {st.dvd[14:0], 1'b0};
      if (r2 >= {1'b0, st.mx}) begin
         o.rem = 16'(r2 - {1'b0, st.mx});
         o.quo = {st.quo[14:0], 1'b1};
      end else begin
         o.rem = r2[15:0];
         o.quo = {st.quo[14:0], 1'b0};
      end
      return o;
   endfunction

   function automatic bdiv_type blend_step(input bdiv_type st);
      logic [20:0] r2;
      bdiv_type    o;
      o     = st;
      r2    = {st.rem, st.dvd[16]};
      o.dvd = {st.dvd[15:0], 1'b0};
      if (r2 >= {1'b0, st.den}) begin
         o.rem = 20'(r2 - {1'b0, st.den});
         o.quo = {st.quo[15:0], 1'b1};
      end else begin
         o.rem = r2[19:0];
         o.quo = {st.quo[15:0], 1'b0};
      end
      return o;
   endfunction

endpackage

`default_nettype wire

### design/variable_error_diffusion_coeffs.sv
// Each sample is issued as three neighbor jobs into a 23-stage pipeline: injection,
// position divider, lookup, two multiply stages, blend divider and output register.
// Both restoring dividers do 2 bits per stage. One result per cycle unless stalled;
// a stalled output freezes the whole pipeline. Synchronous reset clears valid bits
// and the job sequencer; channel full-scale registers reset to 255.
// Depends on vedc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module variable_error_diffusion_coeffs (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [15:0]        req_sample,
   input  wire logic [1:0]         req_chan,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [1:0]       rsp_dx,
   output logic                    rsp_dy,
   output logic [15:0]             rsp_weight,
   output logic [1:0]              rsp_out_chan,
   output logic                    rsp_last,
   input  wire logic               csr_write_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import vedc_pkg::*;

   logic [15:0] max_ff [CHANNELS];
   nb_type      nb_ff, nb_in;
   logic        adv;

   // injection stage
   logic        v0_ff;
   logic [15:0] s0_sample_ff;
   logic [15:0] s0_mx_ff;
   logic [1:0]  s0_chan_ff;
   nb_type      s0_nb_ff;

   pdiv_type    pd_ff [POS_STAGES+1];
   pdiv_type    pd_in [POS_STAGES+1];
   logic        pv_ff [POS_STAGES+1];

   // lookup stage
   logic        lv_ff;
   logic [1:0]  l_chan_ff;
   nb_type      l_nb_ff;
   logic [9:0]  l_clo_ff, l_slo_ff, l_chi_ff, l_shi_ff;
   logic [7:0]  l_f_ff;

   // multiply stages
   logic        m1v_ff, m2v_ff;
   logic [1:0]  m1_chan_ff, m2_chan_ff;
   nb_type      m1_nb_ff, m2_nb_ff;
   logic [19:0] m1_p1_ff, m1_p2_ff, m1_den_ff, m2_den_ff;
   logic [7:0]  m1_f_ff;
   logic [28:0] m2_t1_ff, m2_t2_ff;
   logic [28:0] num_sum;

   bdiv_type    bd_ff [BLEND_STAGES+1];
   bdiv_type    bd_in [BLEND_STAGES+1];
   logic        bv_ff [BLEND_STAGES+1];
   bdiv_type    fin;

   logic        rsp_valid_ff;
   logic signed [1:0] rsp_dx_ff;
   logic        rsp_dy_ff, rsp_last_ff;
   logic [15:0] rsp_weight_ff;
   logic [1:0]  rsp_chan_ff;

   logic [15:0] pos;
   logic [7:0]  lo_idx, hi_idx;
   coef_type    ent_lo, ent_hi;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(adv && nb_ff == NB_DOWN);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) max_ff[i] <= CSR_RESET;
      end else if (csr_write_en) begin
         max_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      nb_in = nb_ff;
      if (req_valid) begin
         unique case (nb_ff)
            NB_RIGHT:    nb_in = NB_DOWNLEFT;
            NB_DOWNLEFT: nb_in = NB_DOWN;
            NB_DOWN:     nb_in = NB_RIGHT;
            default:     nb_in = NB_RIGHT;
         endcase
      end
   end

   // position divider, table lookup, numerator sum and blend divider
   always_comb begin
      pd_in[0].chan = s0_chan_ff;
      pd_in[0].nb   = s0_nb_ff;
      pd_in[0].sat  = (s0_sample_ff >= s0_mx_ff);
      pd_in[0].mx   = s0_mx_ff;
      {pd_in[0].rem, pd_in[0].dvd} = 32'(POS_MAX) * 32'(s0_sample_ff);
      pd_in[0].quo  = '0;
      for (int j = 1; j <= POS_STAGES; j++) pd_in[j] = pos_step(pos_step(pd_ff[j-1]));

      pos    = pd_ff[POS_STAGES].sat ? POS_MAX : pd_ff[POS_STAGES].quo;
      lo_idx = pos[15:8];
      hi_idx = (lo_idx == 8'hFF) ? lo_idx : lo_idx + 8'd1;
      ent_lo = table_entry(lo_idx);
      ent_hi = table_entry(hi_idx);

      // numerator: c_lo*s_hi*(256-f) + c_hi*s_lo*f, bounded by 2^28
      num_sum = m2_t1_ff + m2_t2_ff;
      bd_in[0].chan = m2_chan_ff;
      bd_in[0].nb   = m2_nb_ff;
      bd_in[0].den  = m2_den_ff;
      bd_in[0].rem  = {1'b0, num_sum[27:9]};
      bd_in[0].dvd  = {num_sum[8:0], 8'd0};
      bd_in[0].quo  = '0;
      for (int j = 1; j <= BLEND_STAGES; j++) bd_in[j] = blend_step(blend_step(bd_ff[j-1]));

      fin = blend_step(bd_ff[BLEND_STAGES]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff        <= NB_RIGHT;
         v0_ff        <= 1'b0;
         lv_ff        <= 1'b0;
         m1v_ff       <= 1'b0;
         m2v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j <= POS_STAGES; j++) pv_ff[j] <= 1'b0;
         for (int j = 0; j <= BLEND_STAGES; j++) bv_ff[j] <= 1'b0;
      end else if (adv) begin
         nb_ff  <= nb_in;
         v0_ff  <= req_valid;
         pv_ff[0] <= v0_ff;
         for (int j = 1; j <= POS_STAGES; j++) pv_ff[j] <= pv_ff[j-1];
         lv_ff  <= pv_ff[POS_STAGES];
         m1v_ff <= lv_ff;
         m2v_ff <= m1v_ff;
         bv_ff[0] <= m2v_ff;
         for (int j = 1; j <= BLEND_STAGES; j++) bv_ff[j] <= bv_ff[j-1];
         rsp_valid_ff <= bv_ff[BLEND_STAGES];
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_sample_ff <= req_sample;
         s0_chan_ff   <= req_chan;
         s0_nb_ff     <= nb_ff;
         s0_mx_ff     <= max_ff[req_chan];
         for (int j = 0; j <= POS_STAGES; j++) pd_ff[j] <= pd_in[j];

         l_chan_ff <= pd_ff[POS_STAGES].chan;
         l_nb_ff   <= pd_ff[POS_STAGES].nb;
         l_f_ff    <= pos[7:0];
         l_slo_ff  <= ent_lo.s;
         l_shi_ff  <= ent_hi.s;
         unique case (pd_ff[POS_STAGES].nb)
            NB_RIGHT:    begin l_clo_ff <= ent_lo.r;  l_chi_ff <= ent_hi.r;  end
            NB_DOWNLEFT: begin l_clo_ff <= ent_lo.dl; l_chi_ff <= ent_hi.dl; end
            NB_DOWN:     begin l_clo_ff <= ent_lo.d;  l_chi_ff <= ent_hi.d;  end
            default:     begin l_clo_ff <= ent_lo.d;  l_chi_ff <= ent_hi.d;  end
         endcase

         m1_chan_ff <= l_chan_ff;
         m1_nb_ff   <= l_nb_ff;
         m1_f_ff    <= l_f_ff;
         m1_p1_ff   <= 20'(l_clo_ff) * 20'(l_shi_ff);
         m1_p2_ff   <= 20'(l_chi_ff) * 20'(l_slo_ff);
         m1_den_ff  <= 20'(l_slo_ff) * 20'(l_shi_ff);

         m2_chan_ff <= m1_chan_ff;
         m2_nb_ff   <= m1_nb_ff;
         m2_den_ff  <= m1_den_ff;
         m2_t1_ff   <= 29'(m1_p1_ff) * 29'(9'd256 - {1'b0, m1_f_ff});
         m2_t2_ff   <= 29'(m1_p2_ff) * 29'(m1_f_ff);

         for (int j = 0; j <= BLEND_STAGES; j++) bd_ff[j] <= bd_in[j];

         rsp_weight_ff <= fin.quo[16] ? WEIGHT_MAX : fin.quo[15:0];
         rsp_chan_ff   <= fin.chan;
         rsp_dy_ff     <= (fin.nb != NB_RIGHT);
         rsp_last_ff   <= (fin.nb == NB_DOWN);
         unique case (fin.nb)
            NB_RIGHT:    rsp_dx_ff <= 2'sb01;
            NB_DOWNLEFT: rsp_dx_ff <= 2'sb11;
            NB_DOWN:     rsp_dx_ff <= 2'sb00;
            default:     rsp_dx_ff <= 2'sb00;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dx       = rsp_dx_ff;
   assign rsp_dy       = rsp_dy_ff;
   assign rsp_weight   = rsp_weight_ff;
   assign rsp_out_chan = rsp_chan_ff;
   assign rsp_last     = rsp_last_ff;

   // the right neighbor lies on the current row
   a_right_same_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dx == 2'sb01 |-> !rsp_dy)
      else $error("right neighbor result carries a row offset");

   // the run ends on the down neighbor
   a_last_is_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_dx == 2'sb00 && rsp_dy)
      else $error("last result is not the down neighbor");

   // a sample is taken only when its third job is issued
   a_accept_on_down: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s0_nb_ff == NB_DOWN && v0_ff)
      else $error("sample accepted before all three jobs were issued");

   // a held output freezes the divider pipeline
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(bd_ff[BLEND_STAGES]) && $stable(pd_ff[POS_STAGES]))
      else $error("pipeline moved while output was stalled");

endmodule

`default_nettype wire

### dv/variable_error_diffusion_coeffs_tb.sv
// Testbench for variable_error_diffusion_coeffs: directed table, full-scale extremes,
// then random samples with bursty input and stalled output, all checked against a
// local weight predictor. Depends on vedc_pkg for the table layout types and sizes.
`timescale 1ns / 1ps
`default_nettype none

module variable_error_diffusion_coeffs_tb;
   import vedc_pkg::*;

   typedef struct packed {
      logic signed [1:0] dx;
      logic              dy;
      logic [15:0]       weight;
      logic [1:0]        chan;
      logic              last;
   } nb_weight_type;

   typedef struct {
      logic [15:0] sample;
      logic [1:0]  chan;
      bit          known;   // weight of the right neighbor typed in
      logic [15:0] right_w;
   } stim_row_type;

   localparam int CSR_MAX0 = 0;
   localparam int CSR_MAX1 = 1;
   localparam int CSR_MAX2 = 2;
   localparam int CSR_MAX3 = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [15:0] req_sample = '0;
   logic [1:0] req_chan = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [1:0] rsp_dx;
   logic rsp_dy;
   logic [15:0] rsp_weight;
   logic [1:0] rsp_out_chan;
   logic rsp_last;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   logic [15:0] full_scale [CHANNELS];
   nb_weight_type expected_weights [$];
   int errors = 0;
   int n_samples = 0;
   int n_results = 0;
   bit hold_long = 1'b0;
   bit stall_on = 1'b0;

   always #10 clock = ~clock;

   variable_error_diffusion_coeffs i_dut (.*);

   // half table stores entry i and 255-i alike
   function automatic coef_type coef_at(input int idx);
      int h;
      h = (idx >= HALF_ENTRIES) ? TABLE_ENTRIES - 1 - idx : idx;
      return HALF_TABLE[h];
   endfunction

   function automatic logic [15:0] blend_weight(input longint c_lo, s_lo, c_hi, s_hi, f);
      longint num, den, w;
      num = c_lo * s_hi * (256 - f) + c_hi * s_lo * f;
      den = s_lo * s_hi * 256;
      if (den == 0) return 16'd0;
      w = (num * 65536) / den;
      return (w > 65535) ? 16'hFFFF : w[15:0];
   endfunction

   task automatic predict_weights(input logic [15:0] sample, input logic [1:0] chan);
      longint mx, pos, f;
      int lo, hi;
      coef_type a, b;
      nb_weight_type r;
      mx = full_scale[chan];
      if (mx == 0) pos = 65280;
      else begin
         pos = (64'd65280 * sample) / mx;
         if (pos > 65280) pos = 65280;
      end
      lo = int'(pos >> 8);
      f = pos & 255;
      hi = (lo < TABLE_ENTRIES - 1) ? lo + 1 : lo;
      a = coef_at(lo);
      b = coef_at(hi);
      r.chan = chan;
      r.dx = 2'sd1; r.dy = 1'b0; r.last = 1'b0;
      r.weight = blend_weight(a.r, a.s, b.r, b.s, f);
      expected_weights.push_back(r);
      r.dx = -2'sd1; r.dy = 1'b1;
      r.weight = blend_weight(a.dl, a.s, b.dl, b.s, f);
      expected_weights.push_back(r);
      r.dx = 2'sd0; r.last = 1'b1;
      r.weight = blend_weight(a.d, a.s, b.d, b.s, f);
      expected_weights.push_back(r);
   endtask

   task automatic write_full_scale(input int idx, input logic [15:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx[1:0];
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      full_scale[idx] = value;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_weights.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // one sample transaction; gap cycles idle the sender first
   task automatic send_sample(input logic [15:0] sample, input logic [1:0] chan,
                              input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= sample;
      req_chan <= chan;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_weights(sample, chan);
      n_samples++;
   endtask

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_long) rsp_stall <= 1'b1;
      else if (stall_on) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      nb_weight_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (expected_weights.size() == 0) begin
            $error("result with nothing expected: weight %0d", rsp_weight);
            errors++;
         end else begin
            e = expected_weights.pop_front();
            if (rsp_dx !== e.dx) begin
               $error("dx exp %0d got %0d", e.dx, rsp_dx); errors++;
            end
            if (rsp_dy !== e.dy) begin
               $error("dy exp %0d got %0d", e.dy, rsp_dy); errors++;
            end
            if (rsp_weight !== e.weight) begin
               $error("weight exp %0d got %0d", e.weight, rsp_weight); errors++;
            end
            if (rsp_out_chan !== e.chan) begin
               $error("out_chan exp %0d got %0d", e.chan, rsp_out_chan); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   // directed rows; right weights typed in at the table ends, both 13/18
   stim_row_type directed [] = '{
      '{16'd0, 2'd0, 1'b1, 16'd47331},
      '{16'd255, 2'd1, 1'b1, 16'd47331},
      '{16'hFFFF, 2'd2, 1'b1, 16'd47331},
      '{16'd128, 2'd3, 1'b0, 16'd0},
      '{16'd1, 2'd0, 1'b0, 16'd0},
      '{16'd254, 2'd1, 1'b0, 16'd0},
      '{16'd64, 2'd2, 1'b0, 16'd0},
      '{16'd200, 2'd3, 1'b0, 16'd0},
      '{16'd127, 2'd0, 1'b0, 16'd0},
      '{16'h8000, 2'd1, 1'b1, 16'd47331},
      '{16'h5555, 2'd2, 1'b1, 16'd47331},
      '{16'd100, 2'd3, 1'b0, 16'd0}
   };

   task automatic random_phase(input int count, input int smax);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         logic [15:0] s;
         logic [1:0] c;
         c = 2'($urandom_range(0, 3));
         case ($urandom_range(0, 5))
            0: s = 16'($urandom);
            1: s = full_scale[c];
            default: s = 16'($urandom_range(0, smax));
         endcase
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            send_sample(s, c, $urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
         end else send_sample(s, c, 0);
         burst--;
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      for (int i = 0; i < CHANNELS; i++) full_scale[i] = CSR_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_sample(directed[i].sample, directed[i].chan, i % 3);
         // typed-in right weight replaces the predicted one for this transaction
         if (directed[i].known)
            expected_weights[expected_weights.size() - 3].weight = directed[i].right_w;
      end
      req_valid <= 1'b0;
      drain();

      // extremes: zero full scale, max, one, and 1000 on channel 3
      write_full_scale(CSR_MAX0, 16'd0);
      write_full_scale(CSR_MAX1, 16'hFFFF);
      write_full_scale(CSR_MAX2, 16'd1);
      write_full_scale(CSR_MAX3, 16'd1000);
      for (int c = 0; c < CHANNELS; c++) begin
         send_sample(16'd0, c[1:0], 0);
         send_sample(16'd1, c[1:0], 1);
         send_sample(16'hFFFF, c[1:0], 0);
      end
      req_valid <= 1'b0;
      drain();

      stall_on = 1'b1;
      random_phase(62, 16'hFFFF);
      drain();

      write_full_scale(CSR_MAX0, 16'd255);
      write_full_scale(CSR_MAX1, 16'd4095);
      write_full_scale(CSR_MAX2, 16'($urandom_range(1, 65535)));
      write_full_scale(CSR_MAX3, 16'd300);
      // long receiver hold-off while samples keep coming
      fork
         begin
            hold_long = 1'b1;
            repeat (150) @(posedge clock);
            hold_long = 1'b0;
         end
         random_phase(62, 4095);
      join
      drain();

      write_full_scale(CSR_MAX0, 16'($urandom_range(1, 65535)));
      write_full_scale(CSR_MAX1, 16'd1);
      write_full_scale(CSR_MAX2, 16'd0);
      write_full_scale(CSR_MAX3, 16'hFFFF);
      random_phase(62, 16'hFFFF);
      drain();

      $display("Covered %0d samples, %0d neighbor weights, four full-scale settings.",
               n_samples, n_results);
      if (errors == 0 && expected_weights.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
